### rtl/core/scs_pkg.sv
// Shared types and constants for the scene change score block.
// Depends on nothing; the controller, datapath and top level import it.
package scs_pkg;

	// Field widths.
	localparam int LUMA_W     = 8;
	localparam int WIDTH_W    = 10;
	localparam int HEIGHT_W   = 9;
	localparam int PROD_W     = WIDTH_W + HEIGHT_W;
	localparam int MAFD_W     = 16;
	localparam int FRAC_W     = MAFD_W - LUMA_W;
	localparam int SCORE_W    = 17;

	// Configuration port.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = WIDTH_W;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} scs_reg_t;

	localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST  = 10'd320;
	localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 9'd240;

	// Largest mean, 255.0 in Q8.8; a larger quotient saturates here.
	localparam logic [MAFD_W-1:0] MAFD_MAX = 16'd65280;

	// Serial divider: one quotient bit per cycle.
	localparam int DIV_STEPS = MAFD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Score = (m * 64 + 12) / 25, done as a multiply by a reciprocal.
	// The reciprocal ceil(2^27 / 25) is exact for every operand below 2^22.
	localparam int SCORE_X_W   = MAFD_W + 6;
	localparam int RECIP_W     = 23;
	localparam int RECIP_SHIFT = 27;
	localparam int PRODUCT_W   = SCORE_X_W + RECIP_W;
	localparam int SCORE_Q_W   = PRODUCT_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0]   RECIP       = 23'd5368710;
	localparam logic [SCORE_X_W-1:0] SCORE_ROUND = 22'd12;
	localparam logic [SCORE_W-1:0]   SCORE_MAX   = 17'd65536;

	// Channel payloads.
	typedef struct packed {
		logic [LUMA_W-1:0] luma;
	} scs_pixel_t;

	typedef struct packed {
		logic [SCORE_W-1:0] scene_score;
		logic [MAFD_W-1:0]  mean_abs_diff;
		logic               first_frame;
	} scs_result_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic accept;
		logic acc;
		logic div_init;
		logic div_step;
		logic mul;
		logic load_out;
	} scs_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic last_pixel;
	} scs_status_t;

endpackage

### rtl/core/scs_stream_if.sv
// Valid/ready stream interface used for the pixel and result channels.
// The payload type is a parameter; the block uses types from scs_pkg.
interface scs_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/scs_ctrl.sv
// Controller state machine of the scene change score block.
// Depends on scs_pkg for the command and status structs.
module scs_ctrl
	import scs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	output logic        result_valid,
	input  logic        result_ready,
	input  scs_status_t status,
	output scs_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_RUN,
		ST_ACC_LAST,
		ST_DIV_INIT,
		ST_DIV_RUN,
		ST_MUL,
		ST_OUT_WAIT
	} state_t;

	state_t                state_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	logic                  acc_s1;
	logic                  result_valid_q;

	// Commands follow from the state and the handshakes.
	always_comb begin
		cmd          = '0;
		cmd.accept   = pixel_valid && (state_q == ST_RUN);
		cmd.acc      = acc_s1;
		cmd.div_init = (state_q == ST_DIV_INIT);
		cmd.div_step = (state_q == ST_DIV_RUN);
		cmd.mul      = (state_q == ST_MUL);
		cmd.load_out = (state_q == ST_OUT_WAIT) && (!result_valid_q || result_ready);
	end

	assign pixel_ready  = (state_q == ST_RUN);
	assign result_valid = result_valid_q;

	// State, step counter, accumulate strobe and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_RUN;
			div_cnt_q      <= '0;
			acc_s1         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			acc_s1 <= cmd.accept;

			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_RUN: begin
					if (cmd.accept && status.last_pixel) begin
						state_q <= ST_ACC_LAST;
					end
				end
				ST_ACC_LAST: begin
					state_q <= ST_DIV_INIT;
				end
				ST_DIV_INIT: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV_RUN;
				end
				ST_DIV_RUN: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_OUT_WAIT;
				end
				ST_OUT_WAIT: begin
					if (cmd.load_out) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

endmodule

### rtl/core/scs_datapath.sv
// Datapath of the scene change score block: frame store, difference sum,
// serial divider, score multiplier and result register. Depends on scs_pkg.
module scs_datapath
	import scs_pkg::*;
#(
	parameter int MAX_PIXELS = 131072
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  scs_pixel_t             pixel,
	input  scs_cmd_t               cmd,
	output scs_status_t            status,
	output scs_result_t            result
);

	localparam int AW    = $clog2(MAX_PIXELS);
	localparam int CW    = $clog2(MAX_PIXELS + 1);
	localparam int SUM_W = LUMA_W + AW;
	localparam int NUM_W = SUM_W + FRAC_W;
	localparam int CMP_W = (CW > PROD_W) ? CW : PROD_W;

	logic [WIDTH_W-1:0]  frame_width_q;
	logic [HEIGHT_W-1:0] frame_height_q;
	logic [AW-1:0]       idx_q;
	logic [AW-1:0]       idx_s1;
	logic [LUMA_W-1:0]   pix_s1;
	logic [LUMA_W-1:0]   rd_s1;
	logic [SUM_W-1:0]    sum_q;
	logic [MAFD_W-1:0]   prev_mafd_q;
	logic                have_prev_q;
	logic [CW-1:0]       rem_q;
	logic [MAFD_W-1:0]   quo_q;
	logic                ovf_q;
	logic [PRODUCT_W-1:0] product_q;
	scs_result_t         result_q;

	logic [LUMA_W-1:0]   frame_mem [MAX_PIXELS];

	logic [PROD_W-1:0]   area;
	logic [CMP_W-1:0]    area_ext;
	logic [CW-1:0]       count;
	logic [CW-1:0]       idx_next;
	logic [LUMA_W-1:0]   old_pix;
	logic [LUMA_W-1:0]   abs_diff;
	logic [NUM_W-1:0]    numer;
	logic                numer_ovf;
	logic [CW:0]         trial;
	logic                trial_ge;
	logic [MAFD_W-1:0]   mafd;
	logic [MAFD_W-1:0]   mafd_diff;
	logic [MAFD_W-1:0]   min_val;
	logic [SCORE_X_W-1:0] score_x;
	logic [SCORE_Q_W-1:0] score_q;
	logic [SCORE_W-1:0]  score_sat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (scs_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// Pixel count of a frame: an empty frame counts as one pixel, and the
	// count is held to the store depth.
	always_comb begin
		area     = PROD_W'(frame_width_q) * PROD_W'(frame_height_q);
		area_ext = CMP_W'(area);
		if (area == '0) begin
			count = CW'(1);
		end else if (area_ext > CMP_W'(MAX_PIXELS)) begin
			count = CW'(MAX_PIXELS);
		end else begin
			count = CW'(area_ext);
		end
		idx_next          = CW'(idx_q) + CW'(1);
		status.last_pixel = (idx_next >= count);
	end

	// Raster position of the next pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.accept) begin
			idx_q <= status.last_pixel ? '0 : AW'(idx_next);
		end
	end

	// Frame store: read at transfer, write back in the next cycle.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_s1  <= frame_mem[idx_q];
			pix_s1 <= pixel.luma;
			idx_s1 <= idx_q;
		end
		if (cmd.acc) begin
			frame_mem[idx_s1] <= pix_s1;
		end
	end

	// With no stored frame the pixel is compared with itself.
	always_comb begin
		old_pix  = have_prev_q ? rd_s1 : pix_s1;
		abs_diff = (pix_s1 >= old_pix) ? (pix_s1 - old_pix) : (old_pix - pix_s1);
	end

	// Difference sum and the state carried between frames.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			prev_mafd_q <= '0;
			have_prev_q <= 1'b0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + SUM_W'(abs_diff);
		end else if (cmd.load_out) begin
			sum_q       <= '0;
			prev_mafd_q <= mafd;
			have_prev_q <= 1'b1;
		end
	end

	// Restoring divider for (sum * 256 + count / 2) / count. When a frame
	// shrank mid-way the upper part of the numerator can already reach count;
	// the quotient then overflows 16 bits and the mean saturates.
	always_comb begin
		numer     = {sum_q, {FRAC_W{1'b0}}} + NUM_W'(count >> 1);
		numer_ovf = (CW'(numer[NUM_W-1:MAFD_W]) >= count);
		trial     = {rem_q, quo_q[MAFD_W-1]};
		trial_ge  = (trial >= {1'b0, count});
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= CW'(numer[NUM_W-1:MAFD_W]);
			quo_q <= numer[MAFD_W-1:0];
			ovf_q <= numer_ovf;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? CW'(trial - {1'b0, count}) : CW'(trial);
			quo_q <= {quo_q[MAFD_W-2:0], trial_ge};
		end
	end

	// Score operand: min(mafd, |mafd - previous mafd|) * 64 + 12.
	always_comb begin
		mafd      = (ovf_q || (quo_q > MAFD_MAX)) ? MAFD_MAX : quo_q;
		mafd_diff = (mafd >= prev_mafd_q) ? (mafd - prev_mafd_q) : (prev_mafd_q - mafd);
		min_val   = (mafd < mafd_diff) ? mafd : mafd_diff;
		score_x   = {min_val, {(SCORE_X_W - MAFD_W){1'b0}}} + SCORE_ROUND;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			product_q <= PRODUCT_W'(score_x) * PRODUCT_W'(RECIP);
		end
	end

	// Divide by 25 through the reciprocal, then saturate at 1.0.
	always_comb begin
		score_q   = product_q[PRODUCT_W-1:RECIP_SHIFT];
		score_sat = (score_q > SCORE_Q_W'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(score_q);
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.scene_score   <= have_prev_q ? score_sat : '0;
			result_q.mean_abs_diff <= mafd;
			result_q.first_frame   <= !have_prev_q;
		end
	end

	assign result = result_q;

endmodule

### rtl/core/scene_change_score.sv
// Top level of the scene change score block: controller and datapath.
// Depends on scs_pkg, scs_stream_if, scs_ctrl and scs_datapath.
//
//   Channel   Direction  Payload                                     Handshake
//   pixels    in         luma[7:0]                                   valid/ready
//   results   out        scene_score[16:0], mean_abs_diff[15:0],     valid/ready
//                        first_frame
//   cfg       in         cfg_index[0], cfg_data[9:0]                 cfg_we
//
// Pixels of a frame are taken one per cycle while ready is high; each reads the frame
// store at its transfer and is added and written back in the next cycle.
// After the last pixel of a frame, ready stays low while the block adds it, sets up
// and runs the one-bit-a-cycle mean divider, multiplies and loads the result
// register. A result still waiting holds off that load until it is taken.
// Reset clears the counters, sums and valid flags; the frame store needs no
// clearing, since the first frame never uses what it reads from it.
module scene_change_score
	import scs_pkg::*;
#(
	parameter int MAX_PIXELS = 131072
) (
	input  logic                   clk,
	input  logic                   arst_n,
	scs_stream_if.sink             pixels,
	scs_stream_if.source           results,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	scs_cmd_t    cmd;
	scs_status_t status;
	scs_pixel_t  pixel;
	scs_result_t result;
	logic        pixel_ready;
	logic        result_valid;

	assign pixel         = pixels.data;
	assign pixels.ready  = pixel_ready;
	assign results.valid = result_valid;
	assign results.data  = result;

	// Sequencing of pixel transfers and the end-of-frame computation.
	scs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixels.valid),
		.pixel_ready  (pixel_ready),
		.result_valid (result_valid),
		.result_ready (results.ready),
		.status       (status),
		.cmd          (cmd)
	);

	// Frame store, arithmetic and result register.
	scs_datapath #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

`ifndef ASSERT_OFF
	// No pixel is taken while the divider runs.
	a_no_pixel_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !pixels.ready)
		else $error("pixel ready during divide");

	// The transfer of a frame's last pixel closes the input.
	a_close_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.ready && status.last_pixel) |=> !pixels.ready)
		else $error("input open after last pixel of frame");

	// A first-frame result carries a zero score.
	a_first_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.data.first_frame) |-> (results.data.scene_score == '0))
		else $error("nonzero score on first frame");

	// A result is loaded only when the output register is free.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!results.valid || results.ready))
		else $error("result register overwritten");
`endif

endmodule
